### src/ppaq_pkg.sv
// Shared constants, codes and controller/datapath link types for the priority job queue.
`timescale 1ns / 1ps

package ppaq_pkg;

   localparam int QUEUE_DEPTH_DEF   = 16;
   localparam int PRIORITY_BITS_DEF = 3;

   // request command codes (carried on req_tuser)
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_ENQ   = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   // event codes (carried on rsp_tuser)
   localparam logic [2:0] EV_STARTED     = 3'd0;
   localparam logic [2:0] EV_COMPLETED   = 3'd1;
   localparam logic [2:0] EV_INTERRUPTED = 3'd2;
   localparam logic [2:0] EV_REJECTED    = 3'd3;
   localparam logic [2:0] EV_NONE        = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_WALK_RD,
      ST_WALK_CMP,
      ST_PUT,
      ST_ENQ_CHK,
      ST_EMIT_INT_ENQ,
      ST_POP_RD,
      ST_POP_EMIT,
      ST_ADD,
      ST_ADD_CHK,
      ST_EMIT_CLR,
      ST_EMIT_REJ,
      ST_EMIT_NONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic       item_load;  // capture request fields
      logic       rd_head;    // read queue head
      logic       rd_walk;    // read entry below the walk slot
      logic       wr_shift;   // move the read entry up into the walk slot
      logic       wr_new;     // write the new job into the walk slot
      logic       wp_load;    // walk slot := count
      logic       wp_dec;     // walk slot down by one
      logic       cnt_inc;
      logic       cnt_clear;
      logic       pop;        // head becomes the running job
      logic       prog_add;   // saturating progress update
      logic       run_stop;   // drop running job
      logic       emit;       // load the result register
      logic [2:0] emit_kind;
      logic       emit_last;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [1:0] cmd;
      logic       auth;
      logic       busy;
      logic       cnt_zero;
      logic       cnt_full;
      logic       walk_lt;    // read entry ranks below the new job
      logic       wp_one;
      logic       preempt;    // new job outranks an interruptible running job
      logic       start_done; // a job started by this tick completes on it
      logic       add_done;
      logic       out_free;
   } dp_sts_type;

endpackage

### src/preemptive_priority_action_queue_top.sv
// Top level of the preemptive priority job queue: stream ports, sequencer and datapath.
`timescale 1ns / 1ps
//
//   Channel | Direction | Handshake             | Carries
//   --------+-----------+-----------------------+------------------------------------------
//   req_    | in        | req_tvalid/req_tready | one command: tick, enqueue or clear
//   rsp_    | out       | rsp_tvalid/rsp_tready | one event per transfer, tlast on the final
//   csr_    | in        | csr_valid/csr_ready   | authority bit
//
// One request at a time. An enqueue into an empty queue writes the new job at once; otherwise
// it walks the one-read one-write circular job store from the tail, moving each waiting
// entry of lower priority it passes up by one slot, and it interrupts the running job and
// starts the queue head when it preempts. Reset empties the queue and stops the running
// job; no clearing pass runs. A stalled result register holds the sequencer only when a
// further event has to be loaded; the next request is taken while the final event of the
// previous one still waits.

module preemptive_priority_action_queue_top
   import ppaq_pkg::*;
#(
   parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
   parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // job_id[7:0], priority_req[10:8], duration[26:11],
                                   // interruptible[27], elapsed[43:28], zero[47:44]
   input  logic [1:0]  req_tuser,  // cmd[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // event_job[7:0], event_priority[10:8], queued_count[15:11]
   output logic [2:0]  rsp_tuser,  // event_kind[2:0]
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data
);

   dp_cmd_type cmd;
   dp_sts_type sts;
   logic [7:0] ev_job;
   logic [2:0] ev_prio;
   logic [4:0] ev_count;

   // authority must be written only between requests (the block does not enforce it): always take it
   assign csr_ready = 1'b1;

   ppaq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ppaq_datapath #(
      .QUEUE_DEPTH   (QUEUE_DEPTH),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_data          (csr_data),
      .req_cmd           (req_tuser),
      .req_job_id        (req_tdata[7:0]),
      .req_priority      (req_tdata[10:8]),
      .req_duration      (req_tdata[26:11]),
      .req_interruptible (req_tdata[27]),
      .req_elapsed       (req_tdata[43:28]),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_kind          (rsp_tuser),
      .rsp_job           (ev_job),
      .rsp_priority      (ev_prio),
      .rsp_count         (ev_count),
      .rsp_last          (rsp_tlast)
   );

   // pack event fields, lowest first
   assign rsp_tdata = {ev_count, ev_prio, ev_job};

   // leave idle right after taking a request
   a_one_request: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken twice in a row");

   // never start a job from an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> !sts.cnt_zero)
      else $error("pop from empty queue");

   // never overwrite an event still waiting for transfer
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("result register overwritten");

   // never grow a full queue
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_inc |-> !sts.cnt_full)
      else $error("insert into full queue");

endmodule

### src/ppaq_ctrl.sv
// Sequencer for the priority job queue: decodes one request and steps the datapath.
`timescale 1ns / 1ps

module ppaq_ctrl
   import ppaq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   state_type state_ff, state_in;
   logic      started_ff, started_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         started_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         started_ff <= started_in;
      end
   end

   // next state
   always_comb begin
      state_in   = state_ff;
      started_in = started_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in   = ST_DECODE;
               started_in = 1'b0;
            end
         end
         ST_DECODE: begin
            if (sts.cmd == CMD_TICK && sts.auth) begin
               if (sts.busy)          state_in = ST_ADD;
               else if (sts.cnt_zero) state_in = ST_EMIT_NONE;
               else                   state_in = ST_POP_RD;
            end else if (sts.cmd == CMD_ENQ && sts.auth) begin
               if (sts.cnt_full)      state_in = ST_EMIT_REJ;
               else if (sts.cnt_zero) state_in = ST_PUT;
               else                   state_in = ST_WALK_RD;
            end else if (sts.cmd == CMD_CLEAR) begin
               state_in = sts.busy ? ST_EMIT_CLR : ST_EMIT_NONE;
            end else begin
               state_in = ST_EMIT_NONE;
            end
         end
         ST_WALK_RD: state_in = ST_WALK_CMP;
         ST_WALK_CMP: begin
            if (sts.walk_lt) state_in = sts.wp_one ? ST_PUT : ST_WALK_CMP;
            else             state_in = ST_ENQ_CHK;
         end
         ST_PUT:     state_in = ST_ENQ_CHK;
         ST_ENQ_CHK: state_in = sts.preempt ? ST_EMIT_INT_ENQ : ST_EMIT_NONE;
         ST_EMIT_INT_ENQ: begin
            if (sts.out_free) state_in = ST_POP_RD;
         end
         ST_POP_RD: state_in = ST_POP_EMIT;
         ST_POP_EMIT: begin
            if (sts.out_free) begin
               if (sts.cmd == CMD_TICK) begin
                  state_in   = ST_ADD;
                  started_in = 1'b1;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_ADD: state_in = ST_ADD_CHK;
         ST_ADD_CHK: begin
            if (sts.add_done) begin
               if (sts.out_free) state_in = ST_IDLE;
            end else begin
               state_in = started_ff ? ST_IDLE : ST_EMIT_NONE;
            end
         end
         ST_EMIT_CLR, ST_EMIT_REJ, ST_EMIT_NONE: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      cmd.emit_kind = EV_NONE;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready    = 1'b1;
            cmd.item_load = req_tvalid;
         end
         ST_DECODE: begin
            if (sts.cmd == CMD_ENQ && sts.auth && !sts.cnt_full) cmd.wp_load = 1'b1;
            if (sts.cmd == CMD_CLEAR) cmd.cnt_clear = 1'b1;
         end
         ST_WALK_RD: cmd.rd_walk = 1'b1;
         ST_WALK_CMP: begin
            if (sts.walk_lt) begin
               cmd.wr_shift = 1'b1;
               cmd.wp_dec   = 1'b1;
               cmd.rd_walk  = 1'b1;
            end else begin
               cmd.wr_new  = 1'b1;
               cmd.cnt_inc = 1'b1;
            end
         end
         ST_PUT: begin
            cmd.wr_new  = 1'b1;
            cmd.cnt_inc = 1'b1;
         end
         ST_ENQ_CHK: ;
         ST_EMIT_INT_ENQ: begin
            cmd.emit_kind = EV_INTERRUPTED;
            if (sts.out_free) begin
               cmd.emit     = 1'b1;
               cmd.run_stop = 1'b1;
            end
         end
         ST_POP_RD: cmd.rd_head = 1'b1;
         ST_POP_EMIT: begin
            cmd.emit_kind = EV_STARTED;
            cmd.emit_last = (sts.cmd == CMD_TICK) ? !sts.start_done : 1'b1;
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.pop  = 1'b1;
            end
         end
         ST_ADD: cmd.prog_add = 1'b1;
         ST_ADD_CHK: begin
            cmd.emit_kind = EV_COMPLETED;
            cmd.emit_last = 1'b1;
            if (sts.add_done && sts.out_free) begin
               cmd.emit     = 1'b1;
               cmd.run_stop = 1'b1;
            end
         end
         ST_EMIT_CLR: begin
            cmd.emit_kind = EV_INTERRUPTED;
            cmd.emit_last = 1'b1;
            if (sts.out_free) begin
               cmd.emit     = 1'b1;
               cmd.run_stop = 1'b1;
            end
         end
         ST_EMIT_REJ: begin
            cmd.emit_kind = EV_REJECTED;
            cmd.emit_last = 1'b1;
            cmd.emit      = sts.out_free;
         end
         ST_EMIT_NONE: begin
            cmd.emit_kind = EV_NONE;
            cmd.emit_last = 1'b1;
            cmd.emit      = sts.out_free;
         end
         default: ;
      endcase
   end

endmodule

### src/ppaq_datapath.sv
// Job store, running-job registers, progress adder and result register of the priority queue.
`timescale 1ns / 1ps

module ppaq_datapath
   import ppaq_pkg::*;
#(
   parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
   parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic        csr_data,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_job_id,
   input  logic [2:0]  req_priority,
   input  logic [15:0] req_duration,
   input  logic        req_interruptible,
   input  logic [15:0] req_elapsed,
   input  dp_cmd_type  cmd,
   output dp_sts_type  sts,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_job,
   output logic [2:0]  rsp_priority,
   output logic [4:0]  rsp_count,
   output logic        rsp_last
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int AW = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic                     intr;
      logic [15:0]              dur;
      logic [PRIORITY_BITS-1:0] prio;
      logic [7:0]               id;
   } entry_type;

   entry_type mem [QUEUE_DEPTH];
   entry_type rd_ff, new_ff, run_ff;
   logic [1:0]    cmd_ff;
   logic [15:0]   elapsed_ff;
   logic          auth_ff;
   logic          busy_ff, busy_in;
   logic [15:0]   prog_ff, prog_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] wp_ff, wp_in;
   logic [AW-1:0] head_ff, head_in;
   logic          out_v_ff;
   logic [2:0]    out_kind_ff;
   logic [7:0]    out_job_ff;
   logic [2:0]    out_prio_ff;
   logic [4:0]    out_cnt_ff;
   logic          out_last_ff;

   logic [PRIORITY_BITS+2:0] prio_ext;
   entry_type     new_entry;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [16:0]   sum;
   logic [CW+4:0] cnt_ext;
   entry_type     ev_src;
   logic [PRIORITY_BITS+2:0] ev_prio_ext;
   logic          out_free;

   // logical slot -> physical address in the circular store
   function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] l);
      logic [CW:0] s;
      s = (CW + 1)'(head) + (CW + 1)'(l);
      if (s >= (CW + 1)'(QUEUE_DEPTH)) s = s - (CW + 1)'(QUEUE_DEPTH);
      return s[AW-1:0];
   endfunction

   assign prio_ext       = {{PRIORITY_BITS{1'b0}}, req_priority};
   assign new_entry.id   = req_job_id;
   assign new_entry.prio = prio_ext[PRIORITY_BITS-1:0];
   assign new_entry.dur  = req_duration;
   assign new_entry.intr = req_interruptible;

   always_comb begin
      wp_in = wp_ff;
      if (cmd.wp_load)     wp_in = cnt_ff;
      else if (cmd.wp_dec) wp_in = wp_ff - CW'(1);
   end

   assign rd_addr = cmd.rd_head ? head_ff : phys(head_ff, wp_in - CW'(1));
   assign wr_addr = phys(head_ff, wp_ff);

   always_ff @(posedge clock) begin
      if (cmd.wr_shift)    mem[wr_addr] <= rd_ff;
      else if (cmd.wr_new) mem[wr_addr] <= new_ff;
      if (cmd.rd_head || cmd.rd_walk) rd_ff <= mem[rd_addr];
   end

   assign sum = {1'b0, prog_ff} + {1'b0, elapsed_ff};

   always_comb begin
      cnt_in  = cnt_ff;
      head_in = head_ff;
      busy_in = busy_ff;
      prog_in = prog_ff;
      if (cmd.cnt_clear)    cnt_in = '0;
      else if (cmd.cnt_inc) cnt_in = cnt_ff + CW'(1);
      else if (cmd.pop)     cnt_in = cnt_ff - CW'(1);
      if (cmd.pop) begin
         head_in = (head_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + AW'(1);
         busy_in = 1'b1;
         prog_in = '0;
      end
      if (cmd.run_stop) begin
         busy_in = 1'b0;
         prog_in = '0;
      end
      if (cmd.prog_add) prog_in = sum[16] ? 16'hFFFF : sum[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         auth_ff <= 1'b1;
         busy_ff <= 1'b0;
         prog_ff <= '0;
         cnt_ff  <= '0;
         wp_ff   <= '0;
         head_ff <= '0;
      end else begin
         if (csr_valid) auth_ff <= csr_data;
         busy_ff <= busy_in;
         prog_ff <= prog_in;
         cnt_ff  <= cnt_in;
         wp_ff   <= wp_in;
         head_ff <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.item_load) begin
         cmd_ff     <= req_cmd;
         new_ff     <= new_entry;
         elapsed_ff <= req_elapsed;
      end
      if (cmd.pop) run_ff <= rd_ff;
   end

   // result register
   assign out_free = !out_v_ff || rsp_tready;
   assign cnt_ext  = {5'b0, cnt_in};

   always_comb begin
      case (cmd.emit_kind)
         EV_STARTED:                   ev_src = rd_ff;
         EV_COMPLETED, EV_INTERRUPTED: ev_src = run_ff;
         EV_REJECTED:                  ev_src = new_ff;
         default:                      ev_src = '0;
      endcase
   end
   assign ev_prio_ext = {3'b0, ev_src.prio};

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_v_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_kind_ff <= cmd.emit_kind;
         out_job_ff  <= ev_src.id;
         out_prio_ff <= ev_prio_ext[2:0];
         out_cnt_ff  <= cnt_ext[4:0];
         out_last_ff <= cmd.emit_last;
      end
   end

   assign rsp_tvalid   = out_v_ff;
   assign rsp_kind     = out_kind_ff;
   assign rsp_job      = out_job_ff;
   assign rsp_priority = out_prio_ff;
   assign rsp_count    = out_cnt_ff;
   assign rsp_last     = out_last_ff;

   assign sts.cmd        = cmd_ff;
   assign sts.auth       = auth_ff;
   assign sts.busy       = busy_ff;
   assign sts.cnt_zero   = (cnt_ff == '0);
   assign sts.cnt_full   = (cnt_ff == CW'(QUEUE_DEPTH));
   assign sts.walk_lt    = (rd_ff.prio < new_ff.prio);
   assign sts.wp_one     = (wp_ff == CW'(1));
   assign sts.preempt    = busy_ff && (new_ff.prio > run_ff.prio) && run_ff.intr;
   assign sts.start_done = (elapsed_ff >= rd_ff.dur);
   assign sts.add_done   = (prog_ff >= run_ff.dur);
   assign sts.out_free   = out_free;

endmodule
